// File: rtl/core/sst_pkg.sv
// Package for the scoped symbol table: operation and status codes,
// default sizes and the byte rounding used for the stream payloads.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_BITS_DEF    = 32;
  localparam int REF_BITS_DEF    = 16;
  localparam int KIND_BITS_DEF   = 4;
  localparam int LEVEL_BITS_DEF  = 8;

  localparam int OP_BITS     = 3;
  localparam int STATUS_BITS = 3;
  localparam int SCOPE_BITS  = 9;

  localparam logic [OP_BITS-1:0] OP_LOOKUP      = 3'd0;
  localparam logic [OP_BITS-1:0] OP_LOOKUP_KIND = 3'd1;
  localparam logic [OP_BITS-1:0] OP_PUSH        = 3'd2;
  localparam logic [OP_BITS-1:0] OP_PUSH_UNIQUE = 3'd3;
  localparam logic [OP_BITS-1:0] OP_OPEN        = 3'd4;
  localparam logic [OP_BITS-1:0] OP_CLOSE       = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_DUP        = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_CLOSE_ZERO = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_LEVEL_SAT  = 3'd4;

  function automatic int pad8(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

  function automatic int in_data_bits(input int key_bits, input int kind_bits,
                                      input int ref_bits);
    return pad8(key_bits + kind_bits + ref_bits);
  endfunction

  function automatic int out_data_bits(input int kind_bits, input int ref_bits);
    return pad8(1 + kind_bits + ref_bits + SCOPE_BITS + STATUS_BITS);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/scoped_symbol_table.sv
// Top level of the scoped symbol table: entry RAM, sequencer and output
// register. Depends on sst_pkg, sst_ram, sst_ctrl and sst_out.
//
//   group   dir  payload
//   s_*     in   tuser: op; tdata: name_key, kind, ref_handle
//   m_*     out  tdata: found, kind_out, ref_out, scope_out, status
//
// Lookup, unique push and close scope read one entry a cycle from the entry
// RAM, newest first; a unique push that finds no duplicate then pushes its entry.
// Reset clears the entry count and scope level; RAM contents are not cleared.
// A result waits in the output register while the next transaction is taken.
`timescale 1ns / 1ps
`default_nettype none

module scoped_symbol_table #(
  parameter int TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = sst_pkg::KEY_BITS_DEF,
  parameter int REF_BITS    = sst_pkg::REF_BITS_DEF,
  parameter int KIND_BITS   = sst_pkg::KIND_BITS_DEF,
  parameter int LEVEL_BITS  = sst_pkg::LEVEL_BITS_DEF,
  localparam int IN_W  = sst_pkg::in_data_bits(KEY_BITS, KIND_BITS, REF_BITS),
  localparam int OUT_W = sst_pkg::out_data_bits(KIND_BITS, REF_BITS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // name_key, kind, ref_handle from bit 0 up, zero padded
  input  wire logic [IN_W-1:0]               s_tdata,
  // op
  input  wire logic [sst_pkg::OP_BITS-1:0]   s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // found, kind_out, ref_out, scope_out, status from bit 0 up, zero padded
  output logic      [OUT_W-1:0]              m_tdata
);

  localparam int IDX_BITS = $clog2(TABLE_DEPTH);
  localparam int ENT_BITS = KEY_BITS + KIND_BITS + LEVEL_BITS + REF_BITS;
  localparam int RES_BITS = 1 + KIND_BITS + REF_BITS + sst_pkg::SCOPE_BITS +
                            sst_pkg::STATUS_BITS;

  logic                ram_we;
  logic [IDX_BITS-1:0] ram_waddr;
  logic [ENT_BITS-1:0] ram_wdata;
  logic [IDX_BITS-1:0] ram_raddr;
  logic [ENT_BITS-1:0] ram_rdata;
  logic                res_valid;
  logic                res_ready;
  logic [RES_BITS-1:0] res_data;
  logic [OUT_W-1:0]    res_padded;

  assign res_padded = OUT_W'(res_data);

  sst_ram #(
    .WIDTH (ENT_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sst_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .REF_BITS    (REF_BITS),
    .KIND_BITS   (KIND_BITS),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_key    (s_tdata[KEY_BITS-1:0]),
    .in_kind   (s_tdata[KEY_BITS +: KIND_BITS]),
    .in_ref    (s_tdata[KEY_BITS+KIND_BITS +: REF_BITS]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  sst_out #(
    .WIDTH (OUT_W)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_padded),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/sst_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/sst_ctrl.sv
// Sequencer of the scoped symbol table: decodes operations, scans the entry
// RAM newest first, pushes entries and tracks entry count and scope level.
// Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sst_ctrl #(
  parameter int TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = sst_pkg::KEY_BITS_DEF,
  parameter int REF_BITS    = sst_pkg::REF_BITS_DEF,
  parameter int KIND_BITS   = sst_pkg::KIND_BITS_DEF,
  parameter int LEVEL_BITS  = sst_pkg::LEVEL_BITS_DEF,
  localparam int IDX_BITS   = $clog2(TABLE_DEPTH),
  localparam int ENT_BITS   = KEY_BITS + KIND_BITS + LEVEL_BITS + REF_BITS,
  localparam int RES_BITS   = 1 + KIND_BITS + REF_BITS + sst_pkg::SCOPE_BITS +
                              sst_pkg::STATUS_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [sst_pkg::OP_BITS-1:0]    in_op,
  input  wire logic [KEY_BITS-1:0]            in_key,
  input  wire logic [KIND_BITS-1:0]           in_kind,
  input  wire logic [REF_BITS-1:0]            in_ref,
  output logic                                ram_we,
  output logic      [IDX_BITS-1:0]            ram_waddr,
  output logic      [ENT_BITS-1:0]            ram_wdata,
  output logic      [IDX_BITS-1:0]            ram_raddr,
  input  wire logic [ENT_BITS-1:0]            ram_rdata,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output logic      [RES_BITS-1:0]            res_data
);

  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int SCOPE_BITS = sst_pkg::SCOPE_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                      state;
  logic [CNT_BITS-1:0]             count;
  logic [LEVEL_BITS-1:0]           level;
  logic [IDX_BITS-1:0]             issue_idx;
  logic                            issuing;
  logic                            cmp_valid;
  logic [IDX_BITS-1:0]             cmp_idx;
  logic                            hit;
  logic [sst_pkg::STATUS_BITS-1:0] status;

  logic [sst_pkg::OP_BITS-1:0]     op_q;
  logic [KEY_BITS-1:0]             key_q;
  logic [KIND_BITS-1:0]            kind_q;
  logic [REF_BITS-1:0]             ref_q;
  logic [KIND_BITS-1:0]            hit_kind;
  logic [REF_BITS-1:0]             hit_ref;
  logic [LEVEL_BITS-1:0]           hit_level;

  logic [KEY_BITS-1:0]             rd_key;
  logic [KIND_BITS-1:0]            rd_kind;
  logic [LEVEL_BITS-1:0]           rd_level;
  logic [REF_BITS-1:0]             rd_ref;
  logic                            accept;
  logic                            is_lookup;
  logic                            lk_match;
  logic                            full;
  logic [SCOPE_BITS+LEVEL_BITS-1:0] level_ext;
  logic [SCOPE_BITS-1:0]           scope;

  assign {rd_key, rd_kind, rd_level, rd_ref} = ram_rdata;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_lookup = (op_q == sst_pkg::OP_LOOKUP) || (op_q == sst_pkg::OP_LOOKUP_KIND);
  assign lk_match  = (rd_key == key_q) &&
                     ((op_q != sst_pkg::OP_LOOKUP_KIND) || (rd_kind == kind_q));
  assign full      = (count == CNT_BITS'(TABLE_DEPTH));

  assign ram_we    = (state == S_PUSH) && !full;
  assign ram_waddr = count[IDX_BITS-1:0];
  assign ram_wdata = {key_q, kind_q, level, ref_q};
  assign ram_raddr = issue_idx;

  assign level_ext = {{SCOPE_BITS{1'b0}}, hit_level};
  assign scope     = hit ? level_ext[SCOPE_BITS-1:0] : {SCOPE_BITS{1'b1}};
  assign res_valid = (state == S_DONE);
  assign res_data  = {status, scope,
                      hit ? hit_ref : {REF_BITS{1'b0}},
                      hit ? hit_kind : {KIND_BITS{1'b0}},
                      hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      level     <= '0;
      issue_idx <= '0;
      issuing   <= 1'b0;
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
      status    <= sst_pkg::ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            hit       <= 1'b0;
            status    <= sst_pkg::ST_OK;
            issue_idx <= IDX_BITS'(count - 1'b1);
            issuing   <= 1'b1;
            cmp_valid <= 1'b0;
            unique case (in_op)
              sst_pkg::OP_LOOKUP, sst_pkg::OP_LOOKUP_KIND: begin
                state <= (count == '0) ? S_DONE : S_SCAN;
              end
              sst_pkg::OP_PUSH: begin
                state <= S_PUSH;
              end
              sst_pkg::OP_PUSH_UNIQUE: begin
                state <= (count == '0) ? S_PUSH : S_SCAN;
              end
              sst_pkg::OP_OPEN: begin
                if (level == {LEVEL_BITS{1'b1}}) begin
                  status <= sst_pkg::ST_LEVEL_SAT;
                end else begin
                  level <= level + 1'b1;
                end
                state <= S_DONE;
              end
              sst_pkg::OP_CLOSE: begin
                if (level == '0) begin
                  status <= sst_pkg::ST_CLOSE_ZERO;
                  state  <= S_DONE;
                end else if (count == '0) begin
                  level <= level - 1'b1;
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issuing) begin
            issue_idx <= issue_idx - 1'b1;
            issuing   <= (issue_idx != '0);
            cmp_idx   <= issue_idx;
          end
          cmp_valid <= issuing;
          if (cmp_valid) begin
            case (op_q) inside
              sst_pkg::OP_LOOKUP, sst_pkg::OP_LOOKUP_KIND: begin
                if (lk_match) begin
                  hit   <= 1'b1;
                  state <= S_DONE;
                end else if (cmp_idx == '0) begin
                  state <= S_DONE;
                end
              end
              sst_pkg::OP_PUSH_UNIQUE: begin
                if (rd_level < level) begin
                  state <= S_PUSH;
                end else if (rd_level == level && rd_kind == kind_q && rd_key == key_q) begin
                  status <= sst_pkg::ST_DUP;
                  state  <= S_DONE;
                end else if (cmp_idx == '0) begin
                  state <= S_PUSH;
                end
              end
              default: begin
                if (rd_level >= level) begin
                  count <= CNT_BITS'(cmp_idx);
                  if (cmp_idx == '0) begin
                    level <= level - 1'b1;
                    state <= S_DONE;
                  end
                end else begin
                  level <= level - 1'b1;
                  state <= S_DONE;
                end
              end
            endcase
          end
        end
        S_PUSH: begin
          if (full) begin
            status <= sst_pkg::ST_FULL;
          end else begin
            count <= count + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= in_op;
      key_q  <= in_key;
      kind_q <= in_kind;
      ref_q  <= in_ref;
    end
    if (state == S_SCAN && cmp_valid && is_lookup && lk_match) begin
      hit_kind  <= rd_kind;
      hit_ref   <= rd_ref;
      hit_level <= rd_level;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sst_out.sv
// Output register of the scoped symbol table: holds one result transaction
// until the downstream side takes it. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module sst_out #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             res_valid,
  output logic                  res_ready,
  input  wire logic [WIDTH-1:0] res_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] out_data
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sst_checker.sv
// Port checker for the scoped symbol table, bound to the top level.
// Depends on sst_pkg and scoped_symbol_table.
`timescale 1ns / 1ps
`default_nettype none

module sst_checker #(
  parameter int REF_BITS  = sst_pkg::REF_BITS_DEF,
  parameter int KIND_BITS = sst_pkg::KIND_BITS_DEF,
  localparam int OUT_W  = sst_pkg::out_data_bits(KIND_BITS, REF_BITS),
  localparam int SC_LSB = 1 + KIND_BITS + REF_BITS,
  localparam int ST_LSB = SC_LSB + sst_pkg::SCOPE_BITS
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic [sst_pkg::OP_BITS-1:0] s_tuser,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [OUT_W-1:0]            m_tdata
);

  logic found;
  logic [sst_pkg::STATUS_BITS-1:0] status;

  assign found  = m_tdata[0];
  assign status = m_tdata[ST_LSB +: sst_pkg::STATUS_BITS];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && found |-> status == sst_pkg::ST_OK)
    else $error("hit with non-ok status");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !found |-> m_tdata[SC_LSB-1:1] == '0 &&
                           m_tdata[SC_LSB +: sst_pkg::SCOPE_BITS] == '1)
    else $error("miss with non-empty fields");

  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != sst_pkg::OP_PUSH |=> !s_tready)
    else $error("second transaction taken before result formed");

endmodule

bind scoped_symbol_table sst_checker #(
  .REF_BITS  (REF_BITS),
  .KIND_BITS (KIND_BITS)
) u_sst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for scoped_symbol_table: stream stimulus, a scope and
// entry-stack predictor, and a field-by-field check of every result.
// Depends on sst_pkg and the scoped_symbol_table RTL.
`timescale 1ns / 1ps

module testbench;
  import sst_pkg::*;

  localparam int DEPTH = 256;
  localparam logic [OP_BITS-1:0] OP_UNDEF_A = 3'd6;
  localparam logic [OP_BITS-1:0] OP_UNDEF_B = 3'd7;
  localparam logic [7:0] LEVEL_TOP = 8'hFF;
  localparam logic [SCOPE_BITS-1:0] NO_SCOPE = 9'h1FF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 300;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [15:0]        hnd;
    logic [3:0]         kind;
    logic [31:0]        key;
  } sym_req_t;

  // first member is the top of the packed word: matches m_tdata[32:0]
  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [SCOPE_BITS-1:0]  scope;
    logic [15:0]            hnd;
    logic [3:0]             kind;
    logic                   found;
  } sym_res_t;

  typedef struct {
    sym_req_t rq;
    bit       typed;
    sym_res_t res;
  } dir_row_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // name_key, kind, ref_handle from bit 0 up, zero padded
  logic [55:0] s_tdata  = '0;
  // op
  logic [OP_BITS-1:0] s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // found, kind_out, ref_out, scope_out, status from bit 0 up, zero padded
  logic [39:0] m_tdata;

  scoped_symbol_table DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [31:0] tbl_key  [DEPTH];
  logic [3:0]  tbl_kind [DEPTH];
  logic [7:0]  tbl_lvl  [DEPTH];
  logic [15:0] tbl_hnd  [DEPTH];
  int          tbl_count = 0;
  logic [7:0]  cur_lvl   = '0;

  sym_res_t awaited_results[$];
  sym_res_t drv_res;
  bit       drv_typed = 1'b0;
  sym_res_t mon_res;
  int       errors = 0;
  int       cycles = 0;
  int       n_sent = 0;
  int       n_recv = 0;
  int       sh_lvl = 0;
  logic [31:0] key_pool[12];

  function automatic sym_res_t mk_res(logic found, logic [3:0] kind, logic [15:0] hnd,
                                      logic [SCOPE_BITS-1:0] scope,
                                      logic [STATUS_BITS-1:0] status);
    sym_res_t r;
    r.found  = found;
    r.kind   = kind;
    r.hnd    = hnd;
    r.scope  = scope;
    r.status = status;
    return r;
  endfunction

  function automatic logic [STATUS_BITS-1:0] store_entry(sym_req_t rq);
    if (tbl_count >= DEPTH) return ST_FULL;
    tbl_key[tbl_count]  = rq.key;
    tbl_kind[tbl_count] = rq.kind;
    tbl_lvl[tbl_count]  = cur_lvl;
    tbl_hnd[tbl_count]  = rq.hnd;
    tbl_count++;
    return ST_OK;
  endfunction

  function automatic sym_res_t symtab_result(sym_req_t rq);
    sym_res_t r;
    int i;
    bit hit;
    bit dup;
    bit done;
    r = mk_res(1'b0, '0, '0, NO_SCOPE, ST_OK);
    hit = 1'b0;
    dup = 1'b0;
    done = 1'b0;
    i = tbl_count - 1;
    case (rq.op)
      OP_LOOKUP, OP_LOOKUP_KIND: begin
        while (i >= 0 && !hit) begin
          if (tbl_key[i] == rq.key && (rq.op == OP_LOOKUP || tbl_kind[i] == rq.kind)) begin
            hit = 1'b1;
            r = mk_res(1'b1, tbl_kind[i], tbl_hnd[i], {1'b0, tbl_lvl[i]}, ST_OK);
          end
          i--;
        end
      end
      OP_PUSH: r.status = store_entry(rq);
      OP_PUSH_UNIQUE: begin
        while (i >= 0 && !done) begin
          if (tbl_lvl[i] < cur_lvl) begin
            done = 1'b1;
          end else if (tbl_lvl[i] == cur_lvl && tbl_kind[i] == rq.kind &&
                       tbl_key[i] == rq.key) begin
            dup = 1'b1;
            done = 1'b1;
          end
          i--;
        end
        r.status = dup ? ST_DUP : store_entry(rq);
      end
      OP_OPEN: begin
        if (cur_lvl == LEVEL_TOP) r.status = ST_LEVEL_SAT;
        else cur_lvl++;
      end
      OP_CLOSE: begin
        if (cur_lvl == 0) begin
          r.status = ST_CLOSE_ZERO;
        end else begin
          while (tbl_count > 0 && tbl_lvl[tbl_count-1] >= cur_lvl) tbl_count--;
          cur_lvl--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // input side: predict each accepted transaction
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      mon_res = symtab_result({s_tuser, s_tdata[51:36], s_tdata[35:32], s_tdata[31:0]});
      awaited_results.push_back(drv_typed ? drv_res : mon_res);
    end
  end

  // output side: compare against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: %h", m_tdata);
        errors++;
      end else begin
        check_result(awaited_results.pop_front(), sym_res_t'(m_tdata[32:0]));
      end
    end
  end

  task automatic check_result(sym_res_t e, sym_res_t a);
    if (e.found !== a.found) begin
      $error("found: expected %0d, actual %0d", e.found, a.found);
      errors++;
    end
    if (e.kind !== a.kind) begin
      $error("kind_out: expected %0d, actual %0d", e.kind, a.kind);
      errors++;
    end
    if (e.hnd !== a.hnd) begin
      $error("ref_out: expected %h, actual %h", e.hnd, a.hnd);
      errors++;
    end
    if (e.scope !== a.scope) begin
      $error("scope_out: expected %0d, actual %0d", $signed(e.scope), $signed(a.scope));
      errors++;
    end
    if (e.status !== a.status) begin
      $error("status: expected %0d, actual %0d", e.status, a.status);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, no-stall stretches and one long hold-off
  initial begin
    int gap;
    wait (!rst);
    forever begin
      if (n_recv == 60) gap = HOLD_CYCLES;
      else if ((n_recv / 37) % 4 == 1) gap = 0;
      else gap = $urandom_range(0, 19);
      repeat (gap) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      n_recv++;
    end
  end

  task automatic send_item(sym_req_t rq, bit typed, sym_res_t tres);
    int gap;
    gap = ((n_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid  <= 1'b1;
    s_tuser   <= rq.op;
    s_tdata   <= {4'b0, rq.hnd, rq.kind, rq.key};
    drv_typed = typed;
    drv_res   = tres;
    do @(posedge clk); while (!s_tready);
    n_sent++;
    if (rq.op == OP_OPEN && sh_lvl < 255) sh_lvl++;
    if (rq.op == OP_CLOSE && sh_lvl > 0) sh_lvl--;
  endtask

  task automatic issue(logic [OP_BITS-1:0] op, logic [31:0] key, logic [3:0] kind,
                       logic [15:0] hnd);
    sym_req_t rq;
    rq.op = op;
    rq.key = key;
    rq.kind = kind;
    rq.hnd = hnd;
    send_item(rq, 1'b0, '0);
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 11)];
  endfunction

  function automatic logic [3:0] pick_kind();
    return $urandom_range(0, 1) ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15));
  endfunction

  task automatic refresh_pool();
    foreach (key_pool[i]) key_pool[i] = $urandom;
  endtask

  dir_row_t dir_rows[$];

  task automatic add_row(logic [OP_BITS-1:0] op, logic [31:0] key, logic [3:0] kind,
                         logic [15:0] hnd, bit typed, sym_res_t res);
    dir_row_t row;
    row.rq.op = op;
    row.rq.key = key;
    row.rq.kind = kind;
    row.rq.hnd = hnd;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  initial begin
    sym_res_t miss;
    sym_res_t ok;
    logic [OP_BITS-1:0] op;
    logic [31:0] last_key;
    logic [3:0] last_kind;
    int r;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    miss = mk_res(1'b0, '0, '0, NO_SCOPE, ST_OK);
    ok = miss;
    add_row(OP_LOOKUP,      32'h0,        4'h0, 16'h0,    1, miss);
    add_row(OP_CLOSE,       32'h0,        4'h0, 16'h0,    1,
            mk_res(1'b0, '0, '0, NO_SCOPE, ST_CLOSE_ZERO));
    add_row(OP_PUSH,        32'hFFFFFFFF, 4'hF, 16'hFFFF, 1, ok);
    add_row(OP_LOOKUP,      32'hFFFFFFFF, 4'h0, 16'h0,    1,
            mk_res(1'b1, 4'hF, 16'hFFFF, 9'd0, ST_OK));
    add_row(OP_PUSH,        32'h0,        4'h0, 16'h0,    1, ok);
    add_row(OP_LOOKUP,      32'h0,        4'hF, 16'hFFFF, 1,
            mk_res(1'b1, 4'h0, 16'h0, 9'd0, ST_OK));
    add_row(OP_LOOKUP_KIND, 32'hFFFFFFFF, 4'h0, 16'h0,    1, miss);
    add_row(OP_PUSH_UNIQUE, 32'hFFFFFFFF, 4'hF, 16'h1234, 1,
            mk_res(1'b0, '0, '0, NO_SCOPE, ST_DUP));
    add_row(OP_PUSH_UNIQUE, 32'hFFFFFFFF, 4'h5, 16'h1234, 1, ok);
    add_row(OP_LOOKUP_KIND, 32'hFFFFFFFF, 4'hF, 16'h0,    0, miss);
    add_row(OP_OPEN,        32'h12345678, 4'h3, 16'h0,    1, ok);
    add_row(OP_PUSH_UNIQUE, 32'hFFFFFFFF, 4'hF, 16'hAAAA, 0, miss);
    add_row(OP_LOOKUP,      32'hFFFFFFFF, 4'h0, 16'h0,    0, miss);
    add_row(OP_UNDEF_A,     32'hFFFFFFFF, 4'hF, 16'hFFFF, 1, ok);
    add_row(OP_UNDEF_B,     32'h0,        4'h0, 16'h0,    1, ok);
    add_row(OP_CLOSE,       32'hFFFFFFFF, 4'hF, 16'hFFFF, 0, miss);
    add_row(OP_LOOKUP,      32'hFFFFFFFF, 4'h0, 16'h0,    0, miss);
    add_row(OP_LOOKUP_KIND, 32'h0,        4'h0, 16'h0,    0, miss);
    add_row(OP_PUSH,        32'h55555555, 4'hA, 16'h5555, 0, miss);
    add_row(OP_PUSH_UNIQUE, 32'hAAAAAAAA, 4'h5, 16'hAAAA, 0, miss);
    add_row(OP_LOOKUP,      32'hAAAAAAAA, 4'h0, 16'h0,    0, miss);
    add_row(OP_LOOKUP_KIND, 32'h55555555, 4'hA, 16'h0,    0, miss);
    foreach (dir_rows[i]) send_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].res);

    // nested scopes with mixed traffic; keep pushes off level zero
    refresh_pool();
    issue(OP_OPEN, $urandom, 4'($urandom), 16'($urandom));
    for (int n = 0; n < 230; n++) begin
      if (n % 80 == 79) refresh_pool();
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_LOOKUP;
      else if (r < 45) op = OP_LOOKUP_KIND;
      else if (r < 60) op = OP_PUSH;
      else if (r < 75) op = OP_PUSH_UNIQUE;
      else if (r < 85) op = OP_OPEN;
      else if (r < 95) op = OP_CLOSE;
      else op = $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
      if ((op == OP_PUSH || op == OP_PUSH_UNIQUE) && sh_lvl == 0) op = OP_OPEN;
      issue(op, pick_key(), pick_kind(), 16'($urandom));
    end
    while (sh_lvl > 0) issue(OP_CLOSE, $urandom, 4'($urandom), 16'($urandom));

    // fill the table past its depth inside one scope
    issue(OP_OPEN, $urandom, 4'($urandom), 16'($urandom));
    last_key = '0;
    last_kind = '0;
    repeat (262) begin
      last_key = pick_key();
      last_kind = pick_kind();
      issue($urandom_range(0, 1) ? OP_PUSH : OP_PUSH_UNIQUE, last_key, last_kind,
            16'($urandom));
    end
    issue(OP_PUSH_UNIQUE, last_key, last_kind, 16'($urandom));
    repeat (10) begin
      r = $urandom_range(0, 2);
      op = (r == 0) ? OP_LOOKUP : (r == 1) ? OP_LOOKUP_KIND : OP_PUSH_UNIQUE;
      issue(op, pick_key(), pick_kind(), 16'($urandom));
    end
    issue(OP_CLOSE, $urandom, 4'($urandom), 16'($urandom));
    repeat (4) issue(OP_LOOKUP, pick_key(), pick_kind(), 16'($urandom));

    // climb to the top level and beyond, then unwind past zero
    refresh_pool();
    repeat (257) begin
      if ($urandom_range(0, 9) == 0) issue(OP_PUSH, pick_key(), pick_kind(), 16'($urandom));
      issue(OP_OPEN, $urandom, 4'($urandom), 16'($urandom));
    end
    repeat (10) begin
      r = $urandom_range(0, 3);
      op = (r == 0) ? OP_LOOKUP : (r == 1) ? OP_LOOKUP_KIND :
           (r == 2) ? OP_PUSH : OP_PUSH_UNIQUE;
      issue(op, pick_key(), pick_kind(), 16'($urandom));
    end
    repeat (258) begin
      if ($urandom_range(0, 9) == 0) issue(OP_LOOKUP, pick_key(), pick_kind(), 16'($urandom));
      issue(OP_CLOSE, $urandom, 4'($urandom), 16'($urandom));
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sst_pkg.sv
rtl/core/sst_ram.sv
rtl/core/sst_ctrl.sv
rtl/core/sst_out.sv
rtl/core/scoped_symbol_table.sv
rtl/core/sst_checker.sv
verif/testbench.sv
